// ----- design/rtc_bram_command_controller_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the RTC and battery RAM command controller
// Shared helpers so that every concurrent check uses the same clock and reset.
// ----------------------------------------------------------------------------
`ifndef RTC_BRAM_COMMAND_CONTROLLER_TOP_DEFINES_SVH
`define RTC_BRAM_COMMAND_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rbc check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define RBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rbc check failed: next-cycle rule");

`endif

// ----- design/rbc_pkg.sv -----
// ----------------------------------------------------------------------------
// rbc_pkg
// Types and fixed constants of the RTC and battery RAM command controller.
// ----------------------------------------------------------------------------
package rbc_pkg;

	// Store and timestamp geometry.
	localparam int RAM_DEPTH  = 256;
	localparam int RAM_AW     = $clog2(RAM_DEPTH);
	localparam int TIME_BITS  = 48;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LATENCY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECONDS = 2'd1;

	// Control byte bits.
	localparam int CTL_START_BIT = 7;
	localparam int CTL_READ_BIT  = 6;
	localparam int CTL_LAST_BIT  = 5;

	// Command codes carried in data bits 6:3.
	localparam logic [3:0] CMD_SEC_LO = 4'd0;
	localparam logic [3:0] CMD_SEC_HI = 4'd1;
	localparam logic [3:0] CMD_REG    = 4'd6;
	localparam logic [3:0] CMD_BRAM   = 4'd7;

	// Register selectors carried in data bits 2:0.
	localparam logic [2:0] REG_SEL_TEST = 3'd1;
	localparam logic [2:0] REG_SEL_WP   = 3'd5;
	localparam logic [2:0] REG_SEL_UNK  = 3'd7;

	// Input beat.
	typedef struct packed {
		logic                 mode;
		logic [7:0]           data_byte;
		logic [7:0]           ctl_byte;
		logic [TIME_BITS-1:0] time_now;
	} cmd_t;

	// Result beat.
	typedef struct packed {
		logic [7:0] data_out;
		logic       data_loaded;
		logic       start_cleared;
		logic       protocol_error;
		logic       write_protect;
	} rsp_t;

endpackage

// ----- design/rbc_ram.sv -----
// ----------------------------------------------------------------------------
// rbc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds when re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/rtc_bram_command_controller_top.sv -----
// ----------------------------------------------------------------------------
// rtc_bram_command_controller_top
// Command controller for a battery-backed clock and a 256-byte battery RAM.
// ----------------------------------------------------------------------------
// Usage:
// Each cmd beat is either a control-write event (mode 0) or a status poll
// (mode 1). Every cmd beat produces exactly one rsp beat, in order.
// An accepted beat shows on rsp in the next cycle; the result register and
// the battery RAM read, which is registered inside the memory, update together.
// Throughput is one beat per cycle while rsp_stall is low; all sequencing state
// sits in flip-flops and is updated at accept, so back-to-back beats never wait on each other.
// When the receiver holds rsp_stall, the result register and the RAM read
// data hold, and cmd_stall rises until the pending rsp beat is taken.
// Reset clears the command state, the poll timer and the two configuration
// registers, and clears all 256 RAM valid bits at once, so the RAM reads as
// zero until written; no clearing pass is needed and no beat waits.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the edge
// and are expected only while no beat is in flight.
// ----------------------------------------------------------------------------
`include "rtc_bram_command_controller_top_defines.svh"

module rtc_bram_command_controller_top
	import rbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp
);

	typedef enum logic [3:0] {
		PH_RECV       = 4'd0,
		PH_BRAM_R_ADR = 4'd1,
		PH_BRAM_READ  = 4'd2,
		PH_BRAM_W_ADR = 4'd4,
		PH_BRAM_WRITE = 4'd5,
		PH_REG_TEST   = 4'd6,
		PH_REG_WP     = 4'd7,
		PH_REG_UNK    = 4'd8,
		PH_CLK_READ   = 4'd9,
		PH_CLK_WRITE  = 4'd10
	} phase_t;

	// Configuration and command state.
	logic [CFG_W-1:0]     latency_q;
	logic [CFG_W-1:0]     seconds_q;
	phase_t               phase_q;
	logic [RAM_AW-1:0]    addr_q;
	logic                 high_half_q;
	logic [TIME_BITS-1:0] poll_time_q;
	logic                 poll_started_q;
	logic                 protect_q;
	logic [RAM_DEPTH-1:0] vld_q;

	// Result stage.
	logic                 rsp_valid_q;
	logic                 loaded_s2;
	logic                 from_ram_s2;
	logic                 ram_vld_s2;
	logic [7:0]           clk_byte_s2;
	logic                 cleared_s2;
	logic                 err_s2;
	logic                 protect_s2;
	logic [7:0]           ram_rdata;

	// Next-state values of one step.
	phase_t               phase_d;
	logic [RAM_AW-1:0]    addr_d;
	logic                 high_half_d;
	logic [TIME_BITS-1:0] poll_time_d;
	logic                 poll_started_d;
	logic                 protect_d;
	logic                 loaded_d;
	logic                 from_ram_d;
	logic                 cleared_d;
	logic                 err_d;
	logic                 ram_we;
	logic                 ram_re;

	logic                 adv;
	logic                 acc;
	logic                 ctl_start;
	logic                 ctl_rd;
	logic [3:0]           cmd_code;
	logic                 cmd_rd;
	logic [2:0]           cmd_opt;
	logic [TIME_BITS-1:0] poll_base;
	logic [TIME_BITS-1:0] poll_diff;
	logic                 elapsed;
	logic [7:0]           clk_byte;

	// Handshake: the result register frees up when empty or taken.
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign acc       = cmd_valid && adv;
	assign cmd_stall = !adv;

	assign ctl_start = cmd.ctl_byte[CTL_START_BIT];
	assign ctl_rd    = cmd.ctl_byte[CTL_READ_BIT];
	assign cmd_code  = cmd.data_byte[6:3];
	assign cmd_rd    = cmd.data_byte[7];
	assign cmd_opt   = cmd.data_byte[2:0];

	// Poll timer: the first poll of a transfer latches its own timestamp.
	assign poll_base = poll_started_q ? poll_time_q : cmd.time_now;
	assign poll_diff = cmd.time_now - poll_base;
	assign elapsed   = (cmd.time_now >= poll_base) &&
		(poll_diff >= TIME_BITS'(latency_q));

	// Clock byte picked by the selector latched from the command.
	always_comb begin
		clk_byte = 8'd0;
		if (addr_q[0]) begin
			case ({high_half_q, addr_q[2]})
				2'b00:   clk_byte = seconds_q[7:0];
				2'b01:   clk_byte = seconds_q[15:8];
				2'b10:   clk_byte = seconds_q[23:16];
				2'b11:   clk_byte = seconds_q[31:24];
				default: clk_byte = 8'd0;
			endcase
		end
	end

	// One step of the command machine.
	always_comb begin
		phase_d        = phase_q;
		addr_d         = addr_q;
		high_half_d    = high_half_q;
		poll_time_d    = poll_time_q;
		poll_started_d = poll_started_q;
		protect_d      = protect_q;
		loaded_d       = 1'b0;
		from_ram_d     = 1'b0;
		cleared_d      = 1'b0;
		err_d          = 1'b0;
		ram_we         = 1'b0;
		ram_re         = 1'b0;
		if (cmd.mode) begin
			poll_time_d    = poll_base;
			poll_started_d = 1'b1;
			if (elapsed) begin
				poll_time_d    = '0;
				poll_started_d = 1'b0;
				cleared_d      = 1'b1;
			end
		end else if (!cmd.ctl_byte[CTL_LAST_BIT]) begin
			poll_time_d    = '0;
			poll_started_d = 1'b0;
			phase_d        = PH_RECV;
		end else begin
			case (phase_q)
				PH_RECV: begin
					if (ctl_start && !ctl_rd) begin
						if (cmd_code == CMD_SEC_LO || cmd_code == CMD_SEC_HI) begin
							addr_d      = RAM_AW'(cmd_opt);
							high_half_d = cmd_code[0];
							phase_d     = cmd_rd ? PH_CLK_READ : PH_CLK_WRITE;
						end else if (cmd_code == CMD_REG && !cmd_rd) begin
							if (cmd_opt == REG_SEL_TEST || cmd_opt == REG_SEL_WP ||
								cmd_opt == REG_SEL_UNK) begin
								addr_d      = RAM_AW'(cmd_opt);
								high_half_d = 1'b0;
								if (cmd_opt == REG_SEL_TEST) begin
									phase_d = PH_REG_TEST;
								end else if (cmd_opt == REG_SEL_WP) begin
									phase_d = PH_REG_WP;
								end else begin
									phase_d = PH_REG_UNK;
								end
							end
						end else if (cmd_code == CMD_BRAM) begin
							addr_d  = {cmd_opt, 5'd0};
							phase_d = cmd_rd ? PH_BRAM_R_ADR : PH_BRAM_W_ADR;
						end
					end else begin
						err_d = 1'b1;
					end
				end
				PH_BRAM_R_ADR, PH_BRAM_W_ADR: begin
					if (ctl_start && !ctl_rd) begin
						addr_d  = addr_q | {3'd0, cmd.data_byte[6:2]};
						phase_d = (phase_q == PH_BRAM_R_ADR) ? PH_BRAM_READ : PH_BRAM_WRITE;
					end else begin
						err_d = 1'b1;
					end
				end
				PH_BRAM_READ: begin
					if (ctl_start) begin
						if (ctl_rd) begin
							ram_re     = 1'b1;
							loaded_d   = 1'b1;
							from_ram_d = 1'b1;
						end else begin
							err_d = 1'b1;
						end
					end
				end
				PH_BRAM_WRITE: begin
					if (ctl_start) begin
						if (!ctl_rd) begin
							ram_we = 1'b1;
						end else begin
							err_d = 1'b1;
						end
					end
				end
				PH_REG_WP: begin
					protect_d = cmd.data_byte[7];
				end
				PH_CLK_READ: begin
					if (ctl_start && ctl_rd) begin
						loaded_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Battery RAM; entries never written since reset read as zero.
	rbc_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (acc && ram_we),
		.waddr(addr_q),
		.wdata(cmd.data_byte),
		.re   (acc && ram_re),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	// State, valid bits and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latency_q      <= '0;
			seconds_q      <= '0;
			phase_q        <= PH_RECV;
			addr_q         <= '0;
			high_half_q    <= 1'b0;
			poll_time_q    <= '0;
			poll_started_q <= 1'b0;
			protect_q      <= 1'b0;
			vld_q          <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_LATENCY) begin
					latency_q <= cfg_data;
				end else if (cfg_index == CFG_SECONDS) begin
					seconds_q <= cfg_data;
				end
			end
			if (adv) begin
				rsp_valid_q <= cmd_valid;
			end
			if (acc) begin
				phase_q        <= phase_d;
				addr_q         <= addr_d;
				high_half_q    <= high_half_d;
				poll_time_q    <= poll_time_d;
				poll_started_q <= poll_started_d;
				protect_q      <= protect_d;
				if (ram_we) begin
					vld_q[addr_q] <= 1'b1;
				end
				loaded_s2   <= loaded_d;
				from_ram_s2 <= from_ram_d;
				ram_vld_s2  <= vld_q[addr_q];
				clk_byte_s2 <= clk_byte;
				cleared_s2  <= cleared_d;
				err_s2      <= err_d;
				protect_s2  <= protect_d;
			end
		end
	end

	// Result beat.
	assign rsp_valid = rsp_valid_q;
	always_comb begin
		rsp.data_out = 8'd0;
		if (loaded_s2) begin
			if (from_ram_s2) begin
				rsp.data_out = ram_vld_s2 ? ram_rdata : 8'd0;
			end else begin
				rsp.data_out = clk_byte_s2;
			end
		end
		rsp.data_loaded    = loaded_s2;
		rsp.start_cleared  = cleared_s2;
		rsp.protocol_error = err_s2;
		rsp.write_protect  = protect_s2;
	end

	// Checks on the block's own logic.
	`RBC_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, cmd_stall, rsp_valid && rsp_stall)
	`RBC_ASSERT_NOW(a_dout_zero_unloaded, clk, arst_n, rsp_valid && !rsp.data_loaded,
		rsp.data_out == 8'd0)
	`RBC_ASSERT_NOW(a_load_not_poll, clk, arst_n, rsp_valid && rsp.start_cleared,
		!rsp.data_loaded && !rsp.protocol_error)
	`RBC_ASSERT_NEXT(a_write_marks_valid, clk, arst_n, acc && ram_we, vld_q[$past(addr_q)])

endmodule
